// ===== hw/rtl/gsce_pkg.sv =====
package gsce_pkg;

    localparam int ATTR_W      = 8;
    localparam int ITEM_W      = 10;
    localparam int CNT_W       = 32;
    localparam int ACC_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int DIV_STEPS   = FRAC_W + 1;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int MATCH_W     = $clog2(ATTR_W + 1);
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } gsce_state_t;

    typedef struct packed {
        logic acc_en;
        logic load;
        logic step;
        logic first;
    } gsce_cmd_t;

    function automatic logic [MATCH_W-1:0] bit_count(input logic [ATTR_W-1:0] v);
        logic [MATCH_W-1:0] n;
        n = '0;
        for (int i = 0; i < ATTR_W; i++) begin
            n = n + MATCH_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/gsce_ctrl.sv =====
module gsce_ctrl
    import gsce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    input  logic      m_tready,
    output logic      s_tready,
    output logic      m_tvalid,
    output gsce_cmd_t cmd
);

    gsce_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                cmd.first = (step_reg == '0);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// ===== hw/rtl/gsce_div.sv =====
module gsce_div
    import gsce_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic              first,
    input  logic [ACC_W-1:0]  num,
    input  logic [ACC_W-1:0]  den,
    output logic [FRAC_W-1:0] ratio,
    output logic              ratio_valid
);

    logic [ACC_W:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]  den_reg;
    logic [FRAC_W:0]   quo_reg, quo_next;
    logic [ACC_W:0]    rem_shift;
    logic              ge;

    // The first step tests num >= den, which is the saturation bit of the quotient.
    always_comb
    begin
        rem_shift = first ? rem_reg : {rem_reg[ACC_W-1:0], 1'b0};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_next  = ge ? rem_shift - {1'b0, den_reg} : rem_shift;
        quo_next  = {quo_reg[FRAC_W-1:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign ratio_valid = (den_reg != '0);
    assign ratio = !ratio_valid   ? '0 :
                   quo_reg[FRAC_W] ? '1 : quo_reg[FRAC_W-1:0];

endmodule

// ===== hw/rtl/gsce_datapath.sv =====
module gsce_datapath
    import gsce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gsce_cmd_t         cmd,
    input  logic [ATTR_W-1:0] q_vector,
    input  logic [ITEM_W-1:0] item_index,
    input  logic [ATTR_W-1:0] class_pattern,
    input  logic [CNT_W-1:0]  expected_count,
    input  logic [CNT_W-1:0]  expected_correct,
    input  logic              dina_rule,
    output logic [ITEM_W-1:0] result_item,
    output logic [FRAC_W-1:0] guess,
    output logic [FRAC_W-1:0] slip,
    output logic              guess_valid,
    output logic              slip_valid
);

    logic [ACC_W-1:0]   cnt_non_reg, cor_non_reg, cnt_mas_reg, cor_mas_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [MATCH_W-1:0] match_cnt, threshold;
    logic               nonmastery;
    logic [ACC_W-1:0]   slip_num;

    always_comb
    begin
        match_cnt  = bit_count(q_vector & class_pattern);
        threshold  = dina_rule ? bit_count(q_vector) : MATCH_W'(1);
        nonmastery = match_cnt < threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_non_reg <= '0;
            cor_non_reg <= '0;
            cnt_mas_reg <= '0;
            cor_mas_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_non_reg <= '0;
            cor_non_reg <= '0;
            cnt_mas_reg <= '0;
            cor_mas_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (nonmastery)
            begin
                cnt_non_reg <= cnt_non_reg + ACC_W'(expected_count);
                cor_non_reg <= cor_non_reg + ACC_W'(expected_correct);
            end
            else
            begin
                cnt_mas_reg <= cnt_mas_reg + ACC_W'(expected_count);
                cor_mas_reg <= cor_mas_reg + ACC_W'(expected_correct);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            item_reg <= item_index;
        end
    end

    // More correct than counted in the mastery group means no slips at all.
    assign slip_num = (cor_mas_reg >= cnt_mas_reg) ? '0 : cnt_mas_reg - cor_mas_reg;

    gsce_div u_guess_div (
        .clk         (clk),
        .load        (cmd.load),
        .step        (cmd.step),
        .first       (cmd.first),
        .num         (cor_non_reg),
        .den         (cnt_non_reg),
        .ratio       (guess),
        .ratio_valid (guess_valid)
    );

    gsce_div u_slip_div (
        .clk         (clk),
        .load        (cmd.load),
        .step        (cmd.step),
        .first       (cmd.first),
        .num         (slip_num),
        .den         (cnt_mas_reg),
        .ratio       (slip),
        .ratio_valid (slip_valid)
    );

    assign result_item = item_reg;

endmodule

// ===== hw/rtl/guess_slip_class_split_estimator.sv =====
// Guess and slip estimator for one candidate attribute mask (cfg_wdata). Each request carries
// one latent class of a test item; classes are accepted one per cycle while accumulating and
// split into mastery and non-mastery groups by the DINA or DINO rule given in tuser. The
// request marked tlast closes the item: the block then stops accepting while it hands the sums
// to two dividers, runs a bit-per-cycle restoring division and presents the single result,
// and through any output stall, since the result is held until it is taken. guess and slip are
// unsigned Q0.16, truncated and saturated; a valid bit of 0 marks an empty group, whose
// ratio reads 0. Write the mask only while the block is idle.
module guess_slip_class_split_estimator
    import gsce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [ATTR_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // item_index[9:0], class_pattern[17:10], expected_count[49:18],
    // expected_correct[81:50], zero fill [87:82]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // dina_rule[0]
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_item[9:0], guess[25:10], slip[41:26], zero fill [47:42]
    output logic [M_TDATA_W-1:0] m_tdata,
    // guess_valid[0], slip_valid[1]
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic [ATTR_W-1:0] q_vector_reg;
    gsce_cmd_t         cmd;
    logic [ITEM_W-1:0] result_item;
    logic [FRAC_W-1:0] guess, slip;
    logic              guess_valid, slip_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vector_reg <= '0;
        end
        else if (cfg_we)
        begin
            q_vector_reg <= cfg_wdata;
        end
    end

    gsce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    gsce_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .q_vector         (q_vector_reg),
        .item_index       (s_tdata[9:0]),
        .class_pattern    (s_tdata[17:10]),
        .expected_count   (s_tdata[49:18]),
        .expected_correct (s_tdata[81:50]),
        .dina_rule        (s_tuser),
        .result_item      (result_item),
        .guess            (guess),
        .slip             (slip),
        .guess_valid      (guess_valid),
        .slip_valid       (slip_valid)
    );

    assign m_tdata = {6'b0, slip, guess, result_item};
    assign m_tuser = {slip_valid, guess_valid};

endmodule

// ===== bench/tb_top.sv =====
module tb_top
    import gsce_pkg::*;
();

    localparam int LIMIT_CYCLES = 1000000;
    localparam int MAX_REPORTS  = 100;
    localparam int DIRECTED_N   = 14;
    localparam int PHASE_ITEMS  = 215;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [ATTR_W-1:0] pattern;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  correct;
        logic              dina;
        logic              last;
    } class_req_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [FRAC_W-1:0] guess;
        logic [FRAC_W-1:0] slip;
        logic              guess_ok;
        logic              slip_ok;
    } estimate_t;

    typedef struct packed {
        logic              set_mask;
        logic [ATTR_W-1:0] mask;
        logic [ITEM_W-1:0] item;
        logic [ATTR_W-1:0] pattern;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  correct;
        logic              dina;
        logic              last;
        logic              typed;
        logic [FRAC_W-1:0] guess;
        logic [FRAC_W-1:0] slip;
        logic              guess_ok;
        logic              slip_ok;
    } directed_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [ATTR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Mirror of the block's mask register and its four group sums.
    logic [ATTR_W-1:0] mask_q = '0;
    logic [ACC_W-1:0]  count_non = '0;
    logic [ACC_W-1:0]  correct_non = '0;
    logic [ACC_W-1:0]  count_mas = '0;
    logic [ACC_W-1:0]  correct_mas = '0;

    estimate_t     expected_estimates[$];
    directed_row_t directed_table[0:DIRECTED_N-1];
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;
    bit            tx_calm = 1'b0;
    bit            rx_calm = 1'b0;
    bit            rx_long_hold = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    guess_slip_class_split_estimator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int unsigned ones(input logic [ATTR_W-1:0] v);
        int unsigned n;
        n = 0;
        for (int i = 0; i < ATTR_W; i++)
        begin
            n += 32'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [FRAC_W-1:0] q16_ratio(input logic [ACC_W-1:0] num,
                                                    input logic [ACC_W-1:0] den);
        logic [63:0] quo;
        quo = {num, 16'h0000} / 64'(den);
        return (quo > 64'hFFFF) ? 16'hFFFF : quo[FRAC_W-1:0];
    endfunction

    // Adds one class to its group; on the last class fills in the estimate and clears the sums.
    function automatic bit accumulate_class(input class_req_t r, output estimate_t est);
        int unsigned hits;
        int unsigned need;
        hits = ones(mask_q & r.pattern);
        need = r.dina ? ones(mask_q) : 1;
        if (hits < need)
        begin
            count_non   = count_non + ACC_W'(r.count);
            correct_non = correct_non + ACC_W'(r.correct);
        end
        else
        begin
            count_mas   = count_mas + ACC_W'(r.count);
            correct_mas = correct_mas + ACC_W'(r.correct);
        end
        est = '0;
        if (!r.last)
            return 1'b0;
        est.item = r.item;
        if (count_non != 0)
        begin
            est.guess    = q16_ratio(correct_non, count_non);
            est.guess_ok = 1'b1;
        end
        if (count_mas != 0)
        begin
            if (correct_mas < count_mas)
                est.slip = q16_ratio(count_mas - correct_mas, count_mas);
            est.slip_ok = 1'b1;
        end
        count_non   = '0;
        correct_non = '0;
        count_mas   = '0;
        correct_mas = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned tx_gap();
        return tx_calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Patterns lean toward the mask so that both groups fill under either rule.
    function automatic class_req_t fresh_class(input logic [ITEM_W-1:0] item);
        class_req_t r;
        r.item = item;
        case ($urandom_range(0, 2))
            0: r.pattern = mask_q | ATTR_W'($urandom);
            1: r.pattern = mask_q & ATTR_W'($urandom);
            default: r.pattern = ATTR_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: r.count = '0;
            1, 2, 3: r.count = $urandom_range(0, 32'h0004_0000);
            default: r.count = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: r.correct = $urandom;
            1: r.correct = r.count;
            default: r.correct = $urandom_range(0, r.count);
        endcase
        r.dina = 1'b0;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic offer_class(input class_req_t r, input int unsigned gap,
                               input bit typed, input estimate_t typed_est);
        estimate_t est;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r.correct, r.count, r.pattern, r.item};
        s_tuser  <= r.dina;
        s_tlast  <= r.last;
        do
            @(posedge clk);
        while (!s_tready);
        if (accumulate_class(r, est))
            expected_estimates.push_back(typed ? typed_est : est);
        @(negedge clk);
    endtask

    // The mask is only changed with no request in flight and every result drained.
    task automatic write_mask(input logic [ATTR_W-1:0] v);
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(negedge clk);
        repeat (25) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mask_q = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    initial
    begin : stimulus
        directed_row_t     row;
        class_req_t        r;
        estimate_t         e;
        int unsigned       sent;
        int unsigned       n;
        logic [ITEM_W-1:0] item;
        logic [ATTR_W-1:0] m;
        bit                dina;
        bit                mixed;

        // Rows with typed results: empty groups, empty mask under both rules,
        // saturation at one, truncation. Others go through the predictor.
        directed_table[0]  = '{1'b0, 8'h00, 10'd0, 8'h00, 32'h0, 32'h0, 1'b1, 1'b1,
                               1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0};
        directed_table[1]  = '{1'b0, 8'h00, 10'h3FF, 8'hFF, 32'h10000, 32'h10000, 1'b0, 1'b1,
                               1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0};
        directed_table[2]  = '{1'b0, 8'h00, 10'd2, 8'h00, 32'h20000, 32'h10000, 1'b1, 1'b1,
                               1'b1, 16'h0000, 16'h8000, 1'b0, 1'b1};
        directed_table[3]  = '{1'b0, 8'h00, 10'd3, 8'hAA, 32'h10000, 32'h0, 1'b1, 1'b1,
                               1'b1, 16'h0000, 16'hFFFF, 1'b0, 1'b1};
        directed_table[4]  = '{1'b1, 8'hFF, 10'd4, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
                               1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[5]  = '{1'b0, 8'hFF, 10'd4, 8'h7F, 32'hFFFFFFFF, 32'h0, 1'b1, 1'b0,
                               1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[6]  = '{1'b0, 8'hFF, 10'd4, 8'h01, 32'h30000, 32'h40000, 1'b0, 1'b1,
                               1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[7]  = '{1'b0, 8'hFF, 10'd5, 8'h00, 32'h10000, 32'h0, 1'b0, 1'b1,
                               1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0};
        directed_table[8]  = '{1'b0, 8'hFF, 10'd6, 8'h00, 32'h30000, 32'h10000, 1'b1, 1'b1,
                               1'b1, 16'h5555, 16'h0000, 1'b1, 1'b0};
        directed_table[9]  = '{1'b1, 8'h81, 10'd7, 8'h80, 32'h12345678, 32'h02345678, 1'b1,
                               1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[10] = '{1'b0, 8'h81, 10'd7, 8'h01, 32'h00ABCDEF, 32'h0009ABCD, 1'b0,
                               1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[11] = '{1'b0, 8'h81, 10'd7, 8'h81, 32'h1, 32'h0, 1'b1, 1'b1,
                               1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[12] = '{1'b0, 8'h81, 10'd512, 8'h55, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b0,
                               1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0};
        directed_table[13] = '{1'b1, 8'h80, 10'd1, 8'h7F, 32'h1, 32'h1, 1'b0, 1'b1,
                               1'b1, 16'hFFFF, 16'h0000, 1'b1, 1'b0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row = directed_table[i];
            if (row.set_mask)
                write_mask(row.mask);
            r = '{row.item, row.pattern, row.count, row.correct, row.dina, row.last};
            e = '{row.item, row.guess, row.slip, row.guess_ok, row.slip_ok};
            offer_class(r, tx_gap(), row.typed, e);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: m = 8'hFF;
                1: m = 8'h00;
                2: m = 8'h01;
                3: m = 8'h80;
                default: m = ATTR_W'($urandom);
            endcase
            write_mask(m);
            // The sink sits on the next result while requests keep coming.
            if (ph == 1)
                rx_long_hold = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                n     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                item  = ITEM_W'($urandom);
                dina  = 1'($urandom_range(0, 1));
                mixed = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < n; k++)
                begin
                    r      = fresh_class(item);
                    r.dina = mixed ? 1'($urandom_range(0, 1)) : dina;
                    r.last = (k == n - 1);
                    offer_class(r, tx_gap(), 1'b0, '0);
                    sent++;
                    if (sent % 50 == 0)
                        tx_calm = ($urandom_range(0, 2) == 0);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned hold;
        int unsigned taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_long_hold)
            begin
                hold = 400;
                rx_long_hold = 1'b0;
            end
            else
                hold = rx_calm ? 0 : $urandom_range(0, 9);
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                // Half the time the stall starts only once a result is showing.
                if ($urandom_range(0, 1) == 1)
                begin
                    do
                        @(posedge clk);
                    while (!m_tvalid);
                end
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            taken++;
            if (taken % 40 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        estimate_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_estimates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result expected none actual %0h/%0h",
                             $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_estimates.pop_front();
                check_field("result_item", 32'(want.item), 32'(m_tdata[9:0]));
                check_field("guess", 32'(want.guess), 32'(m_tdata[25:10]));
                check_field("slip", 32'(want.slip), 32'(m_tdata[41:26]));
                check_field("guess_valid", 32'(want.guess_ok), 32'(m_tuser[0]));
                check_field("slip_valid", 32'(want.slip_ok), 32'(m_tuser[1]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
